FILE: rtl/dcs_pkg.sv
// Shared constants, types and helpers for the darkest circle select block.
`timescale 1ns / 1ps
package dcs_pkg;

    localparam int MAX_CIRCLES = 8;
    localparam int COORD_BITS  = 10;

    localparam int FIELD_BITS  = 10;
    localparam int VALUE_BITS  = 8;
    localparam int SUM_BITS    = 28;
    localparam int OUT_IDX_BITS = 3;

    localparam int IDX_BITS = (MAX_CIRCLES > 1) ? $clog2(MAX_CIRCLES) : 1;
    localparam int CNT_BITS = $clog2(MAX_CIRCLES + 1);

    localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [IDX_BITS-1:0]   idx_t;
    typedef logic [SUM_BITS-1:0]   sum_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t r;
    } circle_t;

    // Sum bank control: clear all, add a value to one entry, read that entry.
    typedef struct packed {
        logic                  clear;
        logic                  add;
        idx_t                  idx;
        logic [VALUE_BITS-1:0] value;
    } sum_ctrl_t;

    function automatic coord_t to_coord(input logic [FIELD_BITS-1:0] v);
        logic [COORD_BITS+FIELD_BITS-1:0] w;
        w = {{COORD_BITS{1'b0}}, v};
        return w[COORD_BITS-1:0];
    endfunction

    function automatic logic [FIELD_BITS-1:0] from_coord(input coord_t v);
        logic [COORD_BITS+FIELD_BITS-1:0] w;
        w = {{FIELD_BITS{1'b0}}, v};
        return w[FIELD_BITS-1:0];
    endfunction

endpackage

FILE: rtl/dcs_dist_unit.sv
// Shared distance unit: tells whether a pixel lies strictly inside one circle.
`timescale 1ns / 1ps
module dcs_dist_unit (
    input  dcs_pkg::coord_t  pix_col,
    input  dcs_pkg::coord_t  pix_row,
    input  dcs_pkg::circle_t circle,
    output logic             in_circle
);
    import dcs_pkg::*;

    coord_t                  dx;
    coord_t                  dy;
    logic [2*COORD_BITS-1:0] dx2;
    logic [2*COORD_BITS-1:0] dy2;
    logic [2*COORD_BITS-1:0] r2;
    logic [2*COORD_BITS:0]   d2;

    always_comb begin
        dx  = (pix_col >= circle.x) ? (pix_col - circle.x) : (circle.x - pix_col);
        dy  = (pix_row >= circle.y) ? (pix_row - circle.y) : (circle.y - pix_row);
        dx2 = dx * dx;
        dy2 = dy * dy;
        r2  = circle.r * circle.r;
        d2  = {1'b0, dx2} + {1'b0, dy2};
        in_circle = (d2 < {1'b0, r2});
    end

endmodule

FILE: rtl/dcs_sum_bank.sv
// Per-circle intensity sums with saturating add and one read port.
`timescale 1ns / 1ps
module dcs_sum_bank (
    input  logic               aclk,
    input  logic               aresetn,
    input  dcs_pkg::sum_ctrl_t ctrl,
    output dcs_pkg::sum_t      rd_sum
);
    import dcs_pkg::*;

    sum_t            sums_reg [MAX_CIRCLES];
    logic [SUM_BITS:0] add_wide;
    sum_t            add_sat;

    assign rd_sum   = sums_reg[ctrl.idx];
    assign add_wide = {1'b0, rd_sum} + {{(SUM_BITS+1-VALUE_BITS){1'b0}}, ctrl.value};
    assign add_sat  = add_wide[SUM_BITS] ? SUM_MAX : add_wide[SUM_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear) begin
            for (int i = 0; i < MAX_CIRCLES; i++) begin
                sums_reg[i] <= '0;
            end
        end else if (ctrl.add) begin
            sums_reg[ctrl.idx] <= add_sat;
        end
    end

endmodule

FILE: rtl/darkest_circle_select_top.sv
// Top level of the darkest circle select block: table, sequencer and result register.
//
//  channel | direction | ports                                        | handshake
//  --------+-----------+----------------------------------------------+-----------------
//  input   | in        | s_kind s_circle_* s_pixel_* s_last_pixel     | s_valid/s_ready
//  result  | out       | m_best_* m_no_circles m_table_overflow       | m_valid/m_ready
//
// A circle load transaction is written straight into the table.
// A pixel transaction is captured, then the one distance unit visits each loaded circle
// in turn. A last pixel adds a minimum search through the sum bank read port and a
// load of the result register.
// Reset clears the sequencer, circle count, overflow flag, all sums and result valid.
// The result register lets new transactions in while a result waits; only a second
// result that finds the register still full holds the sequencer until m_ready.
`timescale 1ns / 1ps
module darkest_circle_select_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [9:0]  s_circle_x,
    input  logic [9:0]  s_circle_y,
    input  logic [9:0]  s_circle_radius,
    input  logic [9:0]  s_pixel_col,
    input  logic [9:0]  s_pixel_row,
    input  logic [7:0]  s_pixel_value,
    input  logic        s_last_pixel,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_best_index,
    output logic [9:0]  m_best_x,
    output logic [9:0]  m_best_y,
    output logic [9:0]  m_best_radius,
    output logic [27:0] m_best_sum,
    output logic        m_no_circles,
    output logic        m_table_overflow
);
    import dcs_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_SEARCH = 2'd2;
    localparam logic [1:0] ST_DONE   = 2'd3;

    logic [1:0] state_reg, state_next;

    // Frame state.
    circle_t             table_reg [MAX_CIRCLES];
    logic [CNT_BITS-1:0] count_reg;
    logic                overflow_reg;

    // Captured pixel.
    coord_t                pix_col_reg;
    coord_t                pix_row_reg;
    logic [VALUE_BITS-1:0] pix_value_reg;
    logic                  pix_last_reg;

    // Sequencer index and running minimum.
    idx_t    idx_reg;
    sum_t    best_sum_reg;
    idx_t    best_idx_reg;
    circle_t best_circle_reg;

    // Result register.
    logic                    m_valid_reg;
    logic [OUT_IDX_BITS-1:0] out_index_reg;
    logic [FIELD_BITS-1:0]   out_x_reg;
    logic [FIELD_BITS-1:0]   out_y_reg;
    logic [FIELD_BITS-1:0]   out_r_reg;
    sum_t                    out_sum_reg;
    logic                    out_none_reg;
    logic                    out_ovf_reg;

    logic      in_fire;
    logic      load_fire;
    logic      pixel_fire;
    logic      idx_last;
    logic      hit;
    logic      take_best;
    logic      out_load;
    circle_t   cur_circle;
    sum_t      rd_sum;
    sum_ctrl_t sum_ctrl;
    logic [IDX_BITS+OUT_IDX_BITS-1:0] best_idx_wide;

    assign s_ready    = (state_reg == ST_IDLE);
    assign in_fire    = s_valid && s_ready;
    assign load_fire  = in_fire && !s_kind;
    assign pixel_fire = in_fire && s_kind;

    assign cur_circle = table_reg[idx_reg];
    assign idx_last   = ((CNT_BITS'(idx_reg) + CNT_BITS'(1)) == count_reg);
    assign take_best  = (idx_reg == '0) || (rd_sum < best_sum_reg);
    assign out_load   = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);
    assign best_idx_wide = {{OUT_IDX_BITS{1'b0}}, best_idx_reg};

    dcs_dist_unit u_dist (
        .pix_col   (pix_col_reg),
        .pix_row   (pix_row_reg),
        .circle    (cur_circle),
        .in_circle (hit)
    );

    always_comb begin
        sum_ctrl.clear = out_load;
        sum_ctrl.add   = (state_reg == ST_SCAN) && hit;
        sum_ctrl.idx   = idx_reg;
        sum_ctrl.value = pix_value_reg;
    end

    dcs_sum_bank u_sums (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (sum_ctrl),
        .rd_sum  (rd_sum)
    );

    // Sequencer: scan every loaded circle, then search on the last pixel.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (pixel_fire) begin
                    if (count_reg != '0) begin
                        state_next = ST_SCAN;
                    end else if (s_last_pixel) begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                if (idx_last) begin
                    state_next = pix_last_reg ? ST_SEARCH : ST_IDLE;
                end
            end
            ST_SEARCH: begin
                if (idx_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            overflow_reg <= 1'b0;
            idx_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;

            // Drop loads beyond table capacity and remember the overflow.
            if (load_fire) begin
                if (count_reg < CNT_BITS'(MAX_CIRCLES)) begin
                    count_reg <= count_reg + CNT_BITS'(1);
                end else begin
                    overflow_reg <= 1'b1;
                end
            end

            // Advance the circle index; restart it at each sweep.
            if ((state_reg == ST_SCAN) || (state_reg == ST_SEARCH)) begin
                idx_reg <= idx_last ? '0 : idx_reg + IDX_BITS'(1);
            end else begin
                idx_reg <= '0;
            end

            if (out_load) begin
                count_reg    <= '0;
                overflow_reg <= 1'b0;
                m_valid_reg  <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg  <= 1'b0;
            end
        end
    end

    // Payload registers: no reset.
    always_ff @(posedge aclk) begin
        if (load_fire && (count_reg < CNT_BITS'(MAX_CIRCLES))) begin
            table_reg[count_reg[IDX_BITS-1:0]] <= '{x: to_coord(s_circle_x),
                                                   y: to_coord(s_circle_y),
                                                   r: to_coord(s_circle_radius)};
        end

        if (pixel_fire) begin
            pix_col_reg   <= to_coord(s_pixel_col);
            pix_row_reg   <= to_coord(s_pixel_row);
            pix_value_reg <= s_pixel_value;
            pix_last_reg  <= s_last_pixel;
        end

        // Hold the running minimum; the first circle always seeds it.
        if ((state_reg == ST_SEARCH) && take_best) begin
            best_sum_reg    <= rd_sum;
            best_idx_reg    <= idx_reg;
            best_circle_reg <= cur_circle;
        end

        if (out_load) begin
            out_none_reg <= (count_reg == '0);
            out_ovf_reg  <= overflow_reg;
            if (count_reg == '0) begin
                out_index_reg <= '0;
                out_x_reg     <= '0;
                out_y_reg     <= '0;
                out_r_reg     <= '0;
                out_sum_reg   <= '0;
            end else begin
                out_index_reg <= best_idx_wide[OUT_IDX_BITS-1:0];
                out_x_reg     <= from_coord(best_circle_reg.x);
                out_y_reg     <= from_coord(best_circle_reg.y);
                out_r_reg     <= from_coord(best_circle_reg.r);
                out_sum_reg   <= best_sum_reg;
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_best_index     = out_index_reg;
    assign m_best_x         = out_x_reg;
    assign m_best_y         = out_y_reg;
    assign m_best_radius    = out_r_reg;
    assign m_best_sum       = out_sum_reg;
    assign m_no_circles     = out_none_reg;
    assign m_table_overflow = out_ovf_reg;

endmodule

FILE: tb/darkest_circle_checker.sv
// Item kind codes and the checker that predicts and compares darkest circle results.
`timescale 1ns / 1ps
package dcs_tb_pkg;

    typedef enum logic {
        ITEM_LOAD  = 1'b0,
        ITEM_PIXEL = 1'b1
    } item_kind_e;

endpackage

module darkest_circle_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_kind,
    input  logic [9:0]  s_circle_x,
    input  logic [9:0]  s_circle_y,
    input  logic [9:0]  s_circle_radius,
    input  logic [9:0]  s_pixel_col,
    input  logic [9:0]  s_pixel_row,
    input  logic [7:0]  s_pixel_value,
    input  logic        s_last_pixel,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [2:0]  m_best_index,
    input  logic [9:0]  m_best_x,
    input  logic [9:0]  m_best_y,
    input  logic [9:0]  m_best_radius,
    input  logic [27:0] m_best_sum,
    input  logic        m_no_circles,
    input  logic        m_table_overflow,
    output int unsigned fail_count,
    output int unsigned picks_pending
);
    import dcs_pkg::*;
    import dcs_tb_pkg::*;

    typedef struct {
        logic [2:0]  index;
        logic [9:0]  x;
        logic [9:0]  y;
        logic [9:0]  radius;
        logic [27:0] sum;
        logic        no_circles;
        logic        overflow;
    } pick_t;

    circle_t     circles [MAX_CIRCLES];
    sum_t        sums    [MAX_CIRCLES];
    int unsigned loaded;
    logic        overflowed;
    pick_t       expected_picks [$];
    pick_t       want;
    int unsigned mismatches;

    function automatic int unsigned field_diff(input string name,
                                               input longint unsigned exp_val,
                                               input longint unsigned act_val);
        if (exp_val != act_val) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_val, act_val);
            return 1;
        end
        return 0;
    endfunction

    function automatic void clear_frame();
        int unsigned i;
        for (i = 0; i < MAX_CIRCLES; i++) begin
            sums[i] = '0;
        end
        loaded     = 0;
        overflowed = 1'b0;
    endfunction

    // Update the table and sums for one accepted transaction; queue a pick on a last pixel.
    task automatic absorb_transaction();
        pick_t       p;
        int unsigned i;
        int unsigned best;
        int unsigned dx;
        int unsigned dy;
        int unsigned rr;
        int unsigned col;
        int unsigned row;
        if (s_kind == ITEM_LOAD) begin
            if (loaded < MAX_CIRCLES) begin
                circles[loaded].x = s_circle_x;
                circles[loaded].y = s_circle_y;
                circles[loaded].r = s_circle_radius;
                loaded++;
            end else begin
                overflowed = 1'b1;
            end
        end else begin
            col = s_pixel_col;
            row = s_pixel_row;
            for (i = 0; i < loaded; i++) begin
                dx = (col >= circles[i].x) ? col - circles[i].x : circles[i].x - col;
                dy = (row >= circles[i].y) ? row - circles[i].y : circles[i].y - row;
                rr = circles[i].r;
                if (dx * dx + dy * dy < rr * rr) begin
                    sums[i] = (sums[i] > SUM_MAX - s_pixel_value) ? SUM_MAX
                                                                   : sums[i] + s_pixel_value;
                end
            end
            if (s_last_pixel) begin
                p = '{default: '0};
                p.overflow = overflowed;
                if (loaded == 0) begin
                    p.no_circles = 1'b1;
                end else begin
                    // strict less-than keeps the lowest index on equal sums
                    best = 0;
                    for (i = 1; i < loaded; i++) begin
                        if (sums[i] < sums[best]) best = i;
                    end
                    p.index  = 3'(best);
                    p.x      = circles[best].x;
                    p.y      = circles[best].y;
                    p.radius = circles[best].r;
                    p.sum    = sums[best];
                end
                expected_picks = {expected_picks, p};
                clear_frame();
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_frame();
            expected_picks.delete();
            mismatches = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_picks.size() == 0) begin
                    $display("%0t: result with nothing expected, expected none, %s %0d sum %0d",
                             $time, "actual index", m_best_index, m_best_sum);
                    mismatches++;
                end else begin
                    want = expected_picks.pop_front();
                    mismatches += field_diff("best_index", want.index, m_best_index);
                    mismatches += field_diff("best_x", want.x, m_best_x);
                    mismatches += field_diff("best_y", want.y, m_best_y);
                    mismatches += field_diff("best_radius", want.radius, m_best_radius);
                    mismatches += field_diff("best_sum", want.sum, m_best_sum);
                    mismatches += field_diff("no_circles", want.no_circles, m_no_circles);
                    mismatches += field_diff("table_overflow", want.overflow, m_table_overflow);
                end
            end
            if (s_valid && s_ready) absorb_transaction();
        end
        fail_count    <= mismatches;
        picks_pending <= expected_picks.size();
    end

endmodule

FILE: tb/testbench.sv
// Testbench top: clock, reset, frame stimulus, result sink and the final verdict.
`timescale 1ns / 1ps
module testbench;
    import dcs_pkg::*;
    import dcs_tb_pkg::*;

    // Run limits. The slowest correct run stays far below the cycle limit: about 1350
    // transactions with their idle gaps and the block's own work, plus result stalls.
    localparam int unsigned CYCLE_LIMIT     = 500000;
    localparam int unsigned RANDOM_ITEMS    = 1300;
    localparam int unsigned PRESSURE_AFTER  = 10;
    localparam int unsigned PRESSURE_CYCLES = 600;
    localparam int unsigned DRAIN_CYCLES    = 60;

    typedef struct {
        item_kind_e  kind;
        logic [9:0]  cx;
        logic [9:0]  cy;
        logic [9:0]  cr;
        logic [9:0]  col;
        logic [9:0]  row;
        logic [7:0]  value;
        logic        last;
    } frame_item_t;

    // Drive every input to a known value from time zero.
    logic        aclk            = 1'b0;
    logic        aresetn         = 1'b0;
    logic        s_valid         = 1'b0;
    logic        s_ready;
    logic        s_kind          = 1'b0;
    logic [9:0]  s_circle_x      = '0;
    logic [9:0]  s_circle_y      = '0;
    logic [9:0]  s_circle_radius = '0;
    logic [9:0]  s_pixel_col     = '0;
    logic [9:0]  s_pixel_row     = '0;
    logic [7:0]  s_pixel_value   = '0;
    logic        s_last_pixel    = 1'b0;
    logic        m_valid;
    logic        m_ready         = 1'b0;
    logic [2:0]  m_best_index;
    logic [9:0]  m_best_x;
    logic [9:0]  m_best_y;
    logic [9:0]  m_best_radius;
    logic [27:0] m_best_sum;
    logic        m_no_circles;
    logic        m_table_overflow;

    int unsigned fail_count;
    int unsigned picks_pending;
    int unsigned items_sent    = 0;
    int unsigned results_taken = 0;
    int unsigned cycle_count   = 0;
    logic        burst_frame   = 1'b0;
    logic        pressure_done = 1'b0;

    darkest_circle_select_top dut (.*);

    darkest_circle_checker checker_i (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Stop a hung run: count cycles and give up at the limit.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("darkest_circle_select_top verification failed");
            $finish;
        end
    end

    // Count delivered results; the receiver uses this to time its long hold-off.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) results_taken <= results_taken + 1;
    end

    // Build a circle load; fill the unused pixel fields with noise so they toggle too.
    function automatic frame_item_t load_item(input int unsigned x, input int unsigned y,
                                              input int unsigned r, input logic last);
        frame_item_t it;
        it.kind  = ITEM_LOAD;
        it.cx    = 10'(x);
        it.cy    = 10'(y);
        it.cr    = 10'(r);
        it.col   = 10'($urandom_range(0, 1023));
        it.row   = 10'($urandom_range(0, 1023));
        it.value = 8'($urandom_range(0, 255));
        it.last  = last;
        return it;
    endfunction

    // Build a pixel; the circle fields carry noise and must be ignored.
    function automatic frame_item_t pixel_item(input int unsigned col, input int unsigned row,
                                               input int unsigned value, input logic last);
        frame_item_t it;
        it.kind  = ITEM_PIXEL;
        it.cx    = 10'($urandom_range(0, 1023));
        it.cy    = 10'($urandom_range(0, 1023));
        it.cr    = 10'($urandom_range(0, 1023));
        it.col   = 10'(col);
        it.row   = 10'(row);
        it.value = 8'(value);
        it.last  = last;
        return it;
    endfunction

    // Pick a random circle: mostly moderate radii, some tiny, a few very large, up to 1023.
    function automatic frame_item_t random_load();
        int unsigned pick;
        int unsigned r;
        pick = $urandom_range(0, 9);
        if (pick < 2)      r = $urandom_range(0, 3);
        else if (pick < 7) r = $urandom_range(5, 60);
        else if (pick < 9) r = $urandom_range(60, 400);
        else               r = $urandom_range(400, 1023);
        return load_item($urandom_range(0, 1023), $urandom_range(0, 1023), r,
                         1'($urandom_range(0, 1)));
    endfunction

    // Offer one transaction and hold it until accepted. Unless the frame runs back to back,
    // often insert a random idle gap first; never drop valid and raise it in the same step.
    task automatic send(input frame_item_t it);
        int unsigned pick;
        int unsigned gap;
        gap = 0;
        if (!burst_frame) begin
            pick = $urandom_range(0, 99);
            if (pick >= 92)      gap = $urandom_range(8, 30);
            else if (pick >= 55) gap = $urandom_range(1, 3);
        end
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_kind          <= it.kind;
        s_circle_x      <= it.cx;
        s_circle_y      <= it.cy;
        s_circle_radius <= it.cr;
        s_pixel_col     <= it.col;
        s_pixel_row     <= it.row;
        s_pixel_value   <= it.value;
        s_last_pixel    <= it.last;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // Directed frames: empty tables, extreme coordinates, the strict radius boundary,
    // a full table with dropped loads, and equal sums resolved to the lowest index.
    task automatic run_directed();
        int unsigned i;
        burst_frame = 1'b0;
        // empty frame: only a last pixel
        send(pixel_item(0, 0, 0, 1'b1));
        // pixels with no circle loaded change nothing
        send(pixel_item(5, 5, 200, 1'b0));
        send(pixel_item(1023, 1023, 255, 1'b1));
        // extremes; last_pixel on a load must not end the frame, and a pixel
        // sitting exactly on the radius is outside
        send(load_item(0, 0, 0, 1'b1));
        send(load_item(1023, 1023, 1023, 1'b0));
        send(load_item(512, 512, 1, 1'b0));
        send(pixel_item(0, 0, 255, 1'b0));
        send(pixel_item(512, 512, 255, 1'b0));
        send(pixel_item(1023, 0, 128, 1'b1));
        // fill the table, then offer one more load that must be dropped and flagged;
        // only circle 0 sees light, so circles 1..7 tie at zero
        send(load_item(300, 300, 20, 1'b0));
        for (i = 1; i < MAX_CIRCLES; i++) begin
            send(load_item(i * 100, 700, 10, 1'(i % 2)));
        end
        send(load_item(300, 300, 1000, 1'b0));
        send(pixel_item(300, 300, 77, 1'b1));
        // squared distance equal to radius squared stays outside, one less is inside
        send(load_item(10, 10, 3, 1'b0));
        send(load_item(10, 10, 4, 1'b0));
        send(pixel_item(13, 10, 50, 1'b0));
        send(pixel_item(12, 12, 60, 1'b1));
    endtask

    // One random frame: loads (sometimes none, sometimes beyond capacity), then pixels
    // aimed mostly at the loaded circles, now and then a late load between pixels.
    task automatic run_random_frame();
        frame_item_t it;
        int unsigned pick;
        int unsigned n_loads;
        int unsigned n_pixels;
        int unsigned late_load;
        int unsigned k;
        int unsigned j;
        int unsigned known;
        int          span;
        int          col;
        int          row;
        int          cx [MAX_CIRCLES + 4];
        int          cy [MAX_CIRCLES + 4];
        int          cr [MAX_CIRCLES + 4];
        known = 0;
        burst_frame = ($urandom_range(0, 3) == 0);
        pick = $urandom_range(0, 99);
        if (pick < 5)       n_loads = 0;
        else if (pick < 15) n_loads = $urandom_range(MAX_CIRCLES + 1, MAX_CIRCLES + 3);
        else                n_loads = $urandom_range(1, MAX_CIRCLES);
        n_pixels  = $urandom_range(1, 40);
        late_load = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n_pixels - 1) : n_pixels;
        for (k = 0; k < n_loads; k++) begin
            it = random_load();
            cx[known] = it.cx;
            cy[known] = it.cy;
            cr[known] = it.cr;
            known++;
            send(it);
        end
        for (k = 0; k < n_pixels; k++) begin
            if (k == late_load) begin
                it = random_load();
                cx[known] = it.cx;
                cy[known] = it.cy;
                cr[known] = it.cr;
                known++;
                send(it);
            end
            if (known != 0 && $urandom_range(0, 9) < 6) begin
                // land near a circle edge or inside it
                j    = $urandom_range(0, known - 1);
                span = cr[j] + 2;
                col  = cx[j] + int'($urandom_range(0, 2 * span)) - span;
                row  = cy[j] + int'($urandom_range(0, 2 * span)) - span;
                if (col < 0)    col = 0;
                if (col > 1023) col = 1023;
                if (row < 0)    row = 0;
                if (row > 1023) row = 1023;
            end else begin
                col = $urandom_range(0, 1023);
                row = $urandom_range(0, 1023);
            end
            pick = $urandom_range(0, 9);
            send(pixel_item(col, row,
                            (pick == 0) ? 0 : (pick == 1) ? 255 : $urandom_range(0, 255),
                            k == n_pixels - 1));
        end
    endtask

    // Result sink: random stalls, mostly short, a few long, some long ready stretches.
    // Once, hold ready low for a long count so the result register fills and the
    // block pushes back on its input while frames keep coming.
    initial begin : result_sink
        int unsigned pick;
        while (!aresetn) @(posedge aclk);
        forever begin
            pick = $urandom_range(0, 99);
            if (!pressure_done && results_taken >= PRESSURE_AFTER) begin
                pressure_done = 1'b1;
                m_ready <= 1'b0;
                repeat (PRESSURE_CYCLES) @(posedge aclk);
            end else if (pick < 8) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(10, 40)) @(posedge aclk);
            end else if (pick < 35) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
            end else if (pick < 40) begin
                m_ready <= 1'b1;
                repeat ($urandom_range(50, 200)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // Main sequence: reset, directed frames, random frames, drain, verdict.
    initial begin : stimulus
        int unsigned target;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_directed();
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) run_random_frame();
        s_valid <= 1'b0;
        // let the checker count the final transaction, then wait for every
        // predicted result and let the block settle
        @(posedge aclk);
        while (picks_pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && picks_pending == 0) begin
            $display("darkest_circle_select_top verification clean");
        end else begin
            $display("darkest_circle_select_top verification failed");
        end
        $finish;
    end

endmodule
